// ===== rtl/core/derd_pkg.sv =====
// ----------------------------------------------------------------------------
// derd_pkg
// Shared types and constants of the detector event record deframer.
// ----------------------------------------------------------------------------
package derd_pkg;

    localparam logic [31:0] MAGIC_RESET  = 32'hCAFE_CAFE;
    localparam logic [4:0]  HEADER_LAST  = 5'd26;  // position of byte 27 of a header
    localparam logic [4:0]  RECORD_LAST  = 5'd8;   // position of byte 9 of a record
    localparam logic [4:0]  WORD_LAST    = 5'd3;   // position of byte 4 of a word
    localparam logic [4:0]  TS_LAST      = 5'd7;   // header byte that completes the timestamp
    localparam logic [4:0]  WORD_BYTES   = 5'd4;
    localparam logic [4:0]  RECORD_BYTES = 5'd9;

    typedef enum logic [1:0] {
        MODE_HUNT   = 2'd0,
        MODE_HEADER = 2'd1,
        MODE_RECORD = 2'd2
    } t_mode;

    typedef struct packed {
        logic [31:0] event_number;
        logic [27:0] header_timestamp;
        logic        gain_high;
        logic        charge_sign;
        logic [6:0]  channel_number;
        logic [31:0] coarse_tick;
        logic [9:0]  charge_value;
        logic [15:0] fine_tick;
    } t_result;

endpackage

// ===== rtl/core/derd_parser.sv =====
// ----------------------------------------------------------------------------
// derd_parser
// Frame parser: magic hunt, header and record parsing, one byte per request.
// ----------------------------------------------------------------------------
module derd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    input  logic [31:0]       i_magic,
    output logic              o_res_valid,
    output derd_pkg::t_result o_res
);

    derd_pkg::t_mode r_mode, n_mode;
    logic [4:0]      r_pos, n_pos;
    logic [71:0]     r_buf;
    logic [31:0]     r_count, n_count;
    logic [27:0]     r_ts, n_ts;
    logic            r_magic_ok, n_magic_ok;

    logic [71:0] nb;
    logic [31:0] low32;
    logic [31:0] first4;

    assign nb     = {r_buf[63:0], i_byte};
    assign low32  = nb[31:0];
    assign first4 = nb[71:40];

    // next state
    always_comb begin
        n_mode     = r_mode;
        n_pos      = r_pos + 5'd1;
        n_count    = r_count;
        n_ts       = r_ts;
        n_magic_ok = r_magic_ok;
        case (r_mode)
            derd_pkg::MODE_HEADER: begin
                if (r_pos == derd_pkg::WORD_LAST) begin
                    n_magic_ok = (low32 == i_magic);
                end
                if (r_pos == derd_pkg::TS_LAST && r_magic_ok) begin
                    n_ts = low32[31:4];
                end
                if (r_pos >= derd_pkg::HEADER_LAST) begin
                    n_count = r_count + 32'd1;
                    n_pos   = '0;
                    if (r_magic_ok) begin
                        n_mode = derd_pkg::MODE_RECORD;
                    end
                end
            end
            derd_pkg::MODE_RECORD: begin
                if (r_pos >= derd_pkg::RECORD_LAST) begin
                    if (first4 == i_magic) begin
                        n_mode     = derd_pkg::MODE_HEADER;
                        n_magic_ok = 1'b1;
                        n_ts       = nb[39:12];
                        n_pos      = derd_pkg::RECORD_BYTES;
                    end else begin
                        n_pos = '0;
                    end
                end
            end
            default: begin
                n_mode = derd_pkg::MODE_HUNT;
                if (r_pos >= derd_pkg::WORD_LAST) begin
                    if (low32 == i_magic) begin
                        n_mode     = derd_pkg::MODE_HEADER;
                        n_magic_ok = 1'b1;
                        n_pos      = derd_pkg::WORD_BYTES;
                    end else begin
                        n_pos = '0;
                    end
                end
            end
        endcase
    end

    // outputs
    always_comb begin
        o_res_valid = 1'b0;
        case (r_mode)
            derd_pkg::MODE_RECORD: begin
                o_res_valid = i_fire && (r_pos >= derd_pkg::RECORD_LAST) && (first4 != i_magic);
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
        o_res.event_number     = r_count;
        o_res.header_timestamp = r_ts;
        o_res.gain_high        = nb[71];
        o_res.charge_sign      = nb[31];
        o_res.channel_number   = nb[70:64];
        o_res.coarse_tick      = nb[63:32];
        o_res.charge_value     = nb[25:16];
        o_res.fine_tick        = nb[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= derd_pkg::MODE_HUNT;
            r_pos      <= '0;
            r_count    <= '0;
            r_ts       <= '0;
            r_magic_ok <= 1'b0;
        end else if (i_fire) begin
            r_mode     <= n_mode;
            r_pos      <= n_pos;
            r_count    <= n_count;
            r_ts       <= n_ts;
            r_magic_ok <= n_magic_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_buf <= nb;
        end
    end

    a_record_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == derd_pkg::MODE_RECORD |-> r_pos <= derd_pkg::RECORD_LAST)
        else $error("record position out of range");

    a_header_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == derd_pkg::MODE_HEADER |-> r_pos <= derd_pkg::HEADER_LAST)
        else $error("header position out of range");

    a_hunt_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == derd_pkg::MODE_HUNT |-> r_pos <= derd_pkg::WORD_LAST && !r_magic_ok
            && r_count == 32'd0)
        else $error("hunt state inconsistent");

    a_result_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> r_mode == derd_pkg::MODE_RECORD && r_pos == 5'd0)
        else $error("result not at record end");

endmodule

// ===== rtl/core/detector_event_record_deframer.sv =====
// ----------------------------------------------------------------------------
// detector_event_record_deframer
// Byte-stream deframer: magic hunt, event headers, 9-byte channel records.
// ----------------------------------------------------------------------------
// Path from accepting the byte request that completes a record to result
// valid: input register, parser, result register.
// Throughput: one byte per cycle while the skid register is empty.
// Output has a result register plus a skid register; bytes stall only while
// both hold results.
// Reset: synchronous, active low; hunting, counters zero, magic 0xCAFECAFE.
module detector_event_record_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_event_number,
    output logic [27:0] o_header_timestamp,
    output logic        o_gain_high,
    output logic        o_charge_sign,
    output logic [6:0]  o_channel_number,
    output logic [31:0] o_coarse_tick,
    output logic [9:0]  o_charge_value,
    output logic [15:0] o_fine_tick
);

    logic [31:0]       r_magic;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    derd_pkg::t_result r_out;
    logic              r_skid_valid;
    derd_pkg::t_result r_skid;

    logic              fire;
    logic              out_take;
    logic              res_valid;
    derd_pkg::t_result res;

    assign fire       = r_in_valid && !r_skid_valid;
    assign o_in_ready = !r_in_valid || fire;
    assign out_take   = r_out_valid && i_out_ready;

    derd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (r_in_byte),
        .i_magic     (r_magic),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= derd_pkg::MAGIC_RESET;
        end else if (i_cfg_we) begin
            r_magic <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    // result register and skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_take) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= res_valid;
                end
            end else if (res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (res_valid) begin
                r_out <= res;
            end
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_event_number     = r_out.event_number;
    assign o_header_timestamp = r_out.header_timestamp;
    assign o_gain_high        = r_out.gain_high;
    assign o_charge_sign      = r_out.charge_sign;
    assign o_channel_number   = r_out.channel_number;
    assign o_coarse_tick      = r_out.coarse_tick;
    assign o_charge_value     = r_out.charge_value;
    assign o_fine_tick        = r_out.fine_tick;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while output register is empty");

    a_no_fire_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !r_skid_valid)
        else $error("result produced with no room");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && out_take) |=> (r_out_valid && !r_skid_valid))
        else $error("skid result lost");

endmodule
